[rtl/hsla_pkg.sv]
// ----------------------------------------------------------------------------
// hsla_pkg
// Shared constants and types for the HSLA to RGBA colour converter: the
// fixed-point formats, the sector codes and the constant-divider terms.
// ----------------------------------------------------------------------------
package hsla_pkg;

    localparam int HUE_FRAC_BITS = 6;
    localparam int CHANNEL_BITS  = 8;

    localparam int HUE_W = 15;
    localparam int CH_W  = CHANNEL_BITS;

    localparam int MAXV   = (1 << CHANNEL_BITS) - 1;
    localparam int SECTOR = 60 << HUE_FRAC_BITS;
    localparam int TURN   = 360 << HUE_FRAC_BITS;

    localparam int T_W    = $clog2(2 * SECTOR);
    localparam int RAMP_W = $clog2(SECTOR + 1);
    localparam int CN_W   = 2 * CH_W;
    localparam int LM_W   = 2 * CH_W + 1;
    localparam int PROD_W = CN_W + RAMP_W + 1;
    localparam int NUM_W  = PROD_W + 1;

    localparam int DEN   = 2 * MAXV * SECTOR;
    localparam int HALF  = MAXV * SECTOR;
    localparam int DEN_W = $clog2(DEN + 1);

    localparam int             RECIP_SHIFT = NUM_W + 10;
    localparam longint unsigned RECIP      = (64'd1 << RECIP_SHIFT) / longint'(DEN);
    localparam int             RECIP_W     = $clog2(RECIP + 1);
    localparam int             MUL_W       = NUM_W + RECIP_W;
    localparam int             Q_W         = MUL_W - RECIP_SHIFT;

    typedef enum logic [2:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYN = 3'd2,
        SECT_CYN_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } sector_t;

    typedef logic [2:0][NUM_W-1:0] num_vec_t;

endpackage

[rtl/hsla_chroma.sv]
// ----------------------------------------------------------------------------
// hsla_chroma
// First three pipeline stages: hue reduction, sector search, chroma,
// hue ramp and lightness offset numerators.
// ----------------------------------------------------------------------------
module hsla_chroma
    import hsla_pkg::*;
(
    input  logic              clk,
    input  logic [2:0]        load,
    input  logic [HUE_W-1:0]  hue,
    input  logic [CH_W-1:0]   saturation,
    input  logic [CH_W-1:0]   lightness,
    output logic [CN_W-1:0]   cn,
    output logic [RAMP_W-1:0] ramp,
    output logic [LM_W-1:0]   mdiff,
    output sector_t           sector
);

    logic [HUE_W-1:0]  h_next, h_reg;
    logic [CH_W-1:0]   dist_next, dist1_reg;
    logic [CH_W-1:0]   s1_reg, l1_reg, l2_reg;
    logic [CH_W:0]     twol;

    logic [CN_W-1:0]   cn_next, cn2_reg, cn3_reg;
    sector_t           sector_next, sector2_reg, sector3_reg;
    logic [HUE_W-1:0]  base;
    logic [T_W-1:0]    t_next, t_reg;

    logic [T_W-1:0]    tdist;
    logic [RAMP_W-1:0] ramp_next, ramp_reg;
    logic [LM_W-1:0]   lm;
    logic [LM_W-1:0]   mdiff_next, mdiff_reg;

    always_comb
    begin
        h_next    = (hue >= HUE_W'(TURN)) ? hue - HUE_W'(TURN) : hue;
        twol      = {lightness, 1'b0};
        dist_next = (twol >= (CH_W+1)'(MAXV)) ? CH_W'(twol - (CH_W+1)'(MAXV))
                                               : CH_W'((CH_W+1)'(MAXV) - twol);
    end

    always_comb
    begin
        cn_next = CN_W'(CH_W'(MAXV) - dist1_reg) * CN_W'(s1_reg);
        priority if (h_reg >= HUE_W'(5 * SECTOR))
        begin
            sector_next = SECT_MAG_RED;
            base        = HUE_W'(4 * SECTOR);
        end
        else if (h_reg >= HUE_W'(4 * SECTOR))
        begin
            sector_next = SECT_BLU_MAG;
            base        = HUE_W'(4 * SECTOR);
        end
        else if (h_reg >= HUE_W'(3 * SECTOR))
        begin
            sector_next = SECT_CYN_BLU;
            base        = HUE_W'(2 * SECTOR);
        end
        else if (h_reg >= HUE_W'(2 * SECTOR))
        begin
            sector_next = SECT_GRN_CYN;
            base        = HUE_W'(2 * SECTOR);
        end
        else if (h_reg >= HUE_W'(SECTOR))
        begin
            sector_next = SECT_YEL_GRN;
            base        = '0;
        end
        else
        begin
            sector_next = SECT_RED_YEL;
            base        = '0;
        end
        t_next = T_W'(h_reg - base);
    end

    always_comb
    begin
        tdist      = (t_reg >= T_W'(SECTOR)) ? t_reg - T_W'(SECTOR) : T_W'(SECTOR) - t_reg;
        ramp_next  = RAMP_W'(T_W'(SECTOR) - tdist);
        lm         = LM_W'({l2_reg, 1'b0}) * LM_W'(MAXV);
        mdiff_next = (lm >= LM_W'(cn2_reg)) ? lm - LM_W'(cn2_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            h_reg     <= h_next;
            dist1_reg <= dist_next;
            s1_reg    <= saturation;
            l1_reg    <= lightness;
        end
        if (load[1])
        begin
            cn2_reg     <= cn_next;
            sector2_reg <= sector_next;
            t_reg       <= t_next;
            l2_reg      <= l1_reg;
        end
        if (load[2])
        begin
            cn3_reg     <= cn2_reg;
            sector3_reg <= sector2_reg;
            ramp_reg    <= ramp_next;
            mdiff_reg   <= mdiff_next;
        end
    end

    assign cn     = cn3_reg;
    assign ramp   = ramp_reg;
    assign mdiff  = mdiff_reg;
    assign sector = sector3_reg;

endmodule

[rtl/hsla_mix.sv]
// ----------------------------------------------------------------------------
// hsla_mix
// Stages four and five: chroma, secondary and offset numerators over the
// common denominator, sector routing and the rounding bias.
// ----------------------------------------------------------------------------
module hsla_mix
    import hsla_pkg::*;
(
    input  logic              clk,
    input  logic [1:0]        load,
    input  logic [CN_W-1:0]   cn,
    input  logic [RAMP_W-1:0] ramp,
    input  logic [LM_W-1:0]   mdiff,
    input  sector_t           sector,
    output num_vec_t          num
);

    logic [PROD_W-1:0] cv_next, xv_next, mv_next;
    logic [PROD_W-1:0] cv_reg, xv_reg, mv_reg;
    sector_t           sector_reg;
    logic [PROD_W-1:0] r_sel, g_sel, b_sel;
    num_vec_t          num_next, num_reg;

    always_comb
    begin
        xv_next = (PROD_W'(cn) * PROD_W'(ramp)) << 1;
        cv_next = PROD_W'(cn) * PROD_W'(2 * SECTOR);
        mv_next = PROD_W'(mdiff) * PROD_W'(SECTOR);
    end

    always_comb
    begin
        unique case (sector_reg)
            SECT_RED_YEL:
            begin
                r_sel = cv_reg; g_sel = xv_reg; b_sel = '0;
            end
            SECT_YEL_GRN:
            begin
                r_sel = xv_reg; g_sel = cv_reg; b_sel = '0;
            end
            SECT_GRN_CYN:
            begin
                r_sel = '0; g_sel = cv_reg; b_sel = xv_reg;
            end
            SECT_CYN_BLU:
            begin
                r_sel = '0; g_sel = xv_reg; b_sel = cv_reg;
            end
            SECT_BLU_MAG:
            begin
                r_sel = xv_reg; g_sel = '0; b_sel = cv_reg;
            end
            SECT_MAG_RED:
            begin
                r_sel = cv_reg; g_sel = '0; b_sel = xv_reg;
            end
            default:
            begin
                r_sel = cv_reg; g_sel = '0; b_sel = xv_reg;
            end
        endcase
        num_next[0] = NUM_W'(r_sel) + NUM_W'(mv_reg) + NUM_W'(HALF);
        num_next[1] = NUM_W'(g_sel) + NUM_W'(mv_reg) + NUM_W'(HALF);
        num_next[2] = NUM_W'(b_sel) + NUM_W'(mv_reg) + NUM_W'(HALF);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            cv_reg     <= cv_next;
            xv_reg     <= xv_next;
            mv_reg     <= mv_next;
            sector_reg <= sector;
        end
        if (load[1])
        begin
            num_reg <= num_next;
        end
    end

    assign num = num_reg;

endmodule

[rtl/hsla_div.sv]
// ----------------------------------------------------------------------------
// hsla_div
// Two-stage constant divider for one channel: reciprocal estimate, then
// remainder correction and saturation to the channel maximum.
// ----------------------------------------------------------------------------
module hsla_div
    import hsla_pkg::*;
(
    input  logic             clk,
    input  logic [1:0]       load,
    input  logic [NUM_W-1:0] num,
    output logic [CH_W-1:0]  value
);

    logic [MUL_W-1:0] prod;
    logic [Q_W-1:0]   q0_next, q0_reg;
    logic [NUM_W-1:0] n_reg;
    logic [NUM_W-1:0] rem;
    logic [Q_W:0]     q;
    logic [CH_W-1:0]  value_next, value_reg;

    always_comb
    begin
        prod    = MUL_W'(num) * MUL_W'(RECIP);
        q0_next = prod[MUL_W-1:RECIP_SHIFT];
    end

    always_comb
    begin
        rem        = n_reg - NUM_W'(NUM_W'(q0_reg) * NUM_W'(DEN));
        q          = (Q_W+1)'(q0_reg) + (Q_W+1)'(rem >= NUM_W'(DEN));
        value_next = (q > (Q_W+1)'(MAXV)) ? CH_W'(MAXV) : q[CH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            q0_reg <= q0_next;
            n_reg  <= num;
        end
        if (load[1])
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[rtl/hsla_to_rgba_converter_core.sv]
// ----------------------------------------------------------------------------
// hsla_to_rgba_converter_core
// Fixed-point HSLA to RGBA pixel converter, seven-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless hsla_stall is high; every stage
// holds its own valid bit, so a bubble in the stream is squeezed out while
// the output is stalled and hsla_stall rises only when all seven stages are
// full. Hue is taken modulo a full turn, each colour channel is rounded half
// up and saturated to 255, and alpha is carried alongside unchanged.
// ----------------------------------------------------------------------------
module hsla_to_rgba_converter_core
    import hsla_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             hsla_valid,
    output logic             hsla_stall,
    input  logic [HUE_W-1:0] hue,
    input  logic [CH_W-1:0]  saturation,
    input  logic [CH_W-1:0]  lightness,
    input  logic [CH_W-1:0]  alpha_in,
    output logic             rgba_valid,
    input  logic             rgba_stall,
    output logic [CH_W-1:0]  red,
    output logic [CH_W-1:0]  green,
    output logic [CH_W-1:0]  blue,
    output logic [CH_W-1:0]  alpha_out
);

    localparam int STAGES = 7;

    logic [STAGES-1:0]           valid_reg;
    logic [STAGES-1:0]           valid_next;
    logic [STAGES-1:0]           load;
    logic [STAGES-1:0][CH_W-1:0] alpha_reg;

    logic [CN_W-1:0]   cn;
    logic [RAMP_W-1:0] ramp;
    logic [LM_W-1:0]   mdiff;
    sector_t           sector;
    num_vec_t          num;

    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || !rgba_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next = {valid_reg[STAGES-2:0], hsla_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            alpha_reg[0] <= alpha_in;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (load[k])
            begin
                alpha_reg[k] <= alpha_reg[k-1];
            end
        end
    end

    hsla_chroma u_chroma (
        .clk        (clk),
        .load       (load[2:0]),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .cn         (cn),
        .ramp       (ramp),
        .mdiff      (mdiff),
        .sector     (sector)
    );

    hsla_mix u_mix (
        .clk    (clk),
        .load   (load[4:3]),
        .cn     (cn),
        .ramp   (ramp),
        .mdiff  (mdiff),
        .sector (sector),
        .num    (num)
    );

    hsla_div u_div_red (
        .clk   (clk),
        .load  (load[6:5]),
        .num   (num[0]),
        .value (red)
    );

    hsla_div u_div_green (
        .clk   (clk),
        .load  (load[6:5]),
        .num   (num[1]),
        .value (green)
    );

    hsla_div u_div_blue (
        .clk   (clk),
        .load  (load[6:5]),
        .num   (num[2]),
        .value (blue)
    );

    assign hsla_stall = !load[0];
    assign rgba_valid = valid_reg[STAGES-1];
    assign alpha_out  = alpha_reg[STAGES-1];

endmodule

[tb/sv/tb_hsla_to_rgba_converter_core.sv]
// ----------------------------------------------------------------------------
// tb_hsla_to_rgba_converter_core
// Self-checking bench for the HSLA to RGBA pixel converter. A table of
// directed pixels covers the hue sectors, their boundaries, hue wrap-round
// and the saturation and lightness extremes. Random pixels follow, under
// random idling on both channels, a long output hold-off and a drained
// pause. Every output transfer is checked field by field against either
// its table entry or an in-bench integer model of the chroma-based conversion.
// ----------------------------------------------------------------------------
module tb_hsla_to_rgba_converter_core;

    timeunit 1ns;
    timeprecision 1ps;

    import hsla_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 23;
    localparam int N_CASES     = 23;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  light;
        logic [CH_W-1:0]  alpha;
        logic             typed;
        rgba_t            want;
    } pixel_case_t;

    localparam pixel_case_t DIRECTED [N_CASES] = '{
        '{15'd0,     8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
        '{15'd23039, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
        '{15'd32767, 8'd0,   8'd255, 8'd0,   1'b1, '{8'd255, 8'd255, 8'd255, 8'd0}},
        '{15'd11520, 8'd0,   8'd100, 8'd77,  1'b1, '{8'd100, 8'd100, 8'd100, 8'd77}},
        '{15'd8191,  8'd255, 8'd0,   8'd170, 1'b1, '{8'd0,   8'd0,   8'd0,   8'd170}},
        '{15'd0,     8'd255, 8'd255, 8'd85,  1'b1, '{8'd255, 8'd255, 8'd255, 8'd85}},
        '{15'd0,     8'd255, 8'd128, 8'd200, 1'b0, '0},
        '{15'd3840,  8'd255, 8'd128, 8'd1,   1'b0, '0},
        '{15'd7680,  8'd255, 8'd128, 8'd2,   1'b0, '0},
        '{15'd11520, 8'd255, 8'd128, 8'd4,   1'b0, '0},
        '{15'd15360, 8'd255, 8'd128, 8'd8,   1'b0, '0},
        '{15'd19200, 8'd255, 8'd128, 8'd16,  1'b0, '0},
        '{15'd3839,  8'd255, 8'd128, 8'd32,  1'b0, '0},
        '{15'd23039, 8'd255, 8'd128, 8'd64,  1'b0, '0},
        '{15'd23040, 8'd255, 8'd128, 8'd128, 1'b0, '0},
        '{15'd26880, 8'd255, 8'd128, 8'd254, 1'b0, '0},
        '{15'd1920,  8'd255, 8'd127, 8'd3,   1'b0, '0},
        '{15'd9600,  8'd170, 8'd64,  8'd5,   1'b0, '0},
        '{15'd17280, 8'd85,  8'd200, 8'd9,   1'b0, '0},
        '{15'd5000,  8'd1,   8'd1,   8'd17,  1'b0, '0},
        '{15'd21000, 8'd254, 8'd254, 8'd33,  1'b0, '0},
        '{15'd16384, 8'd128, 8'd127, 8'd65,  1'b0, '0},
        '{15'd12345, 8'd93,  8'd170, 8'd129, 1'b0, '0}
    };

    logic             clk;
    logic             rst_n;
    logic             hsla_valid;
    logic             hsla_stall;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  lightness;
    logic [CH_W-1:0]  alpha_in;
    logic             rgba_valid;
    logic             rgba_stall;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha_out;

    rgba_t pending_pixels [$];
    int    errors;
    int    cycles;
    int    hold_left;
    bit    calm;

    hsla_to_rgba_converter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsla_valid (hsla_valid),
        .hsla_stall (hsla_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .alpha_in   (alpha_in),
        .rgba_valid (rgba_valid),
        .rgba_stall (rgba_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha_out  (alpha_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic rgba_t convert_pixel(input logic [HUE_W-1:0] h_in,
                                            input logic [CH_W-1:0]  s_in,
                                            input logic [CH_W-1:0]  l_in,
                                            input logic [CH_W-1:0]  a_in);
        longint unsigned h, s, l, ldist, cn, t, tdist, ramp, cv, xv, lm, mv, v;
        longint unsigned num [3];
        logic [CH_W-1:0] ch [3];
        sector_t sect;
        rgba_t px;
        h = h_in;
        s = s_in;
        l = l_in;
        h = h % TURN;
        ldist = (2 * l >= MAXV) ? 2 * l - MAXV : MAXV - 2 * l;
        cn = (MAXV - ldist) * s;
        t = h % (2 * SECTOR);
        tdist = (t >= SECTOR) ? t - SECTOR : SECTOR - t;
        ramp = SECTOR - tdist;
        cv = cn * 2 * SECTOR;
        xv = cn * ramp * 2;
        lm = 2 * l * MAXV;
        mv = ((lm >= cn) ? lm - cn : 0) * SECTOR;
        sect = sector_t'(h / SECTOR);
        case (sect)
            SECT_RED_YEL: num = '{cv, xv, 0};
            SECT_YEL_GRN: num = '{xv, cv, 0};
            SECT_GRN_CYN: num = '{0, cv, xv};
            SECT_CYN_BLU: num = '{0, xv, cv};
            SECT_BLU_MAG: num = '{xv, 0, cv};
            default:      num = '{cv, 0, xv};
        endcase
        for (int i = 0; i < 3; i++)
        begin
            v = (num[i] + mv + HALF) / DEN;
            if (v > MAXV)
                v = MAXV;
            ch[i] = v[CH_W-1:0];
        end
        px.red   = ch[0];
        px.green = ch[1];
        px.blue  = ch[2];
        px.alpha = a_in;
        return px;
    endfunction

    task automatic report_error(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic send_pixel(input pixel_case_t pc);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            hsla_valid <= 1'b0;
            @(negedge clk);
        end
        hsla_valid <= 1'b1;
        hue        <= pc.hue;
        saturation <= pc.sat;
        lightness  <= pc.light;
        alpha_in   <= pc.alpha;
        @(posedge clk);
        while (hsla_stall)
            @(posedge clk);
        if (pc.typed)
            pending_pixels.push_back(pc.want);
        else
            pending_pixels.push_back(convert_pixel(pc.hue, pc.sat, pc.light, pc.alpha));
        @(negedge clk);
    endtask

    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom_range(0, MAXV));
        endcase
    endfunction

    task automatic send_random(input int count);
        pixel_case_t pc;
        int          k;
        for (int n = 0; n < count; n++)
        begin
            pc = '0;
            case ($urandom_range(0, 9))
                0:
                begin
                    k = $urandom_range(0, 5) * SECTOR + $urandom_range(0, 2);
                    pc.hue = HUE_W'((k == 0) ? 0 : k - 1);
                end
                1:       pc.hue = HUE_W'($urandom_range(TURN, (1 << HUE_W) - 1));
                default: pc.hue = HUE_W'($urandom_range(0, TURN - 1));
            endcase
            pc.sat   = pick_level();
            pc.light = pick_level();
            pc.alpha = CH_W'($urandom_range(0, MAXV));
            send_pixel(pc);
        end
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rgba_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rgba_stall <= 1'b1;
                hold_left--;
            end
            else
                rgba_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_output
        rgba_t want;
        if (rst_n && rgba_valid && !rgba_stall)
        begin
            if (pending_pixels.size() == 0)
                report_error("result transfer with nothing expected");
            else
            begin
                want = pending_pixels.pop_front();
                if (red !== want.red)
                    report_error($sformatf("red %0d, want %0d", red, want.red));
                if (green !== want.green)
                    report_error($sformatf("green %0d, want %0d", green, want.green));
                if (blue !== want.blue)
                    report_error($sformatf("blue %0d, want %0d", blue, want.blue));
                if (alpha_out !== want.alpha)
                    report_error($sformatf("alpha %0d, want %0d", alpha_out, want.alpha));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL hsla_to_rgba_converter_core");
            $finish;
        end
    end

    initial
    begin
        errors     = 0;
        cycles     = 0;
        hold_left  = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        hsla_valid = 1'b0;
        hue        = '0;
        saturation = '0;
        lightness  = '0;
        alpha_in   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
            send_pixel(DIRECTED[i]);

        hsla_valid <= 1'b0;
        drain();
        send_random(150);

        calm = 1'b1;
        send_random(80);

        hold_left = 60;
        send_random(40);
        calm = 1'b0;

        hsla_valid <= 1'b0;
        drain();
        send_random(180);

        hsla_valid <= 1'b0;
        drain();
        repeat (20) @(negedge clk);
        if (pending_pixels.size() != 0)
            report_error("expected results left over");
        if (errors == 0)
            $display("PASS hsla_to_rgba_converter_core");
        else
            $display("FAIL hsla_to_rgba_converter_core");
        $finish;
    end

endmodule

[sim.f]
rtl/hsla_pkg.sv
rtl/hsla_chroma.sv
rtl/hsla_mix.sv
rtl/hsla_div.sv
rtl/hsla_to_rgba_converter_core.sv
tb/sv/tb_hsla_to_rgba_converter_core.sv
